FILE: sv/tba_pkg.sv
// Package for the tangent/bitangent accumulator: widths, action codes,
// vertex word layout and saturation helper. No dependencies.
package tba_pkg;
   localparam int VertexCountDefault  = 4096;
   localparam int FractionBitsDefault = 16;
   localparam int IndexWidth          = 12;
   localparam int DataWidth           = 32;
   localparam int VertexWordWidth     = 5 * DataWidth;
   localparam int SumWordWidth        = 6 * DataWidth;
   localparam int DeltaWidth          = DataWidth + 1;
   localparam int ProductWidth        = 2 * DeltaWidth;
   localparam int DetWidth            = ProductWidth + 1;
   localparam int ReqDataWidth        = 216;
   localparam int RspDataWidth        = 200;

   typedef enum logic [1:0] {
      ACT_LOAD     = 2'd0,
      ACT_TRIANGLE = 2'd1,
      ACT_READ     = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   function automatic logic [DataWidth-1:0] sat_add32(
      input logic [DataWidth-1:0] a,
      input logic [DataWidth-1:0] b,
      output logic                clip
   );
      logic signed [DataWidth:0] s;
      logic [DataWidth-1:0]      r;
      s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      clip = s[DataWidth] != s[DataWidth-1];
      if (clip) r = s[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}}
                                 : {1'b0, {(DataWidth-1){1'b1}}};
      else r = s[DataWidth-1:0];
      return r;
   endfunction
endpackage

FILE: sv/tba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tba_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: sv/tba_divider.sv
// Restoring divider: trunc(num * 2^FracBits / den), saturated to 32 bits.
// One quotient bit a cycle. Depends on tba_pkg.
module tba_divider import tba_pkg::*; #(
   parameter int FracBits = FractionBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DetWidth-1:0]  num,
   input  logic [DetWidth-1:0]  den,
   output logic                 done,
   output logic [DataWidth-1:0] quot,
   output logic                 clip
);
   localparam int NBits = DetWidth + FracBits;
   localparam int CntW  = $clog2(NBits + 1);

   logic [NBits-1:0]    n_ff, n_in;
   logic [DetWidth-1:0] d_ff, d_in;
   logic [DetWidth:0]   r_ff, r_in;
   logic [NBits-1:0]    q_ff, q_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [DetWidth:0]   trial;
   logic [DetWidth-1:0] num_mag, den_mag;
   logic [DataWidth:0]  lim;
   logic                over;

   assign num_mag = num[DetWidth-1] ? (~num + 1'b1) : num;
   assign den_mag = den[DetWidth-1] ? (~den + 1'b1) : den;
   assign trial   = {r_ff[DetWidth-1:0], n_ff[NBits-1]};

   always_comb begin
      n_in = n_ff; d_in = d_ff; r_in = r_ff; q_in = q_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         n_in    = {num_mag, {FracBits{1'b0}}};
         d_in    = den_mag;
         r_in    = '0;
         q_in    = '0;
         cnt_in  = CntW'(NBits);
         neg_in  = num[DetWidth-1] ^ den[DetWidth-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NBits-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign lim  = neg_ff ? {2'b01, {(DataWidth-1){1'b0}}} : {2'b00, {(DataWidth-1){1'b1}}};
   assign over = (q_ff[NBits-1:DataWidth+1] != '0) || (q_ff[DataWidth:0] > lim);
   assign clip = over;
   always_comb begin
      if (over) quot = lim[DataWidth-1:0];
      else quot = q_ff[DataWidth-1:0];
      if (neg_ff) quot = ~quot + 1'b1;
   end
   assign done = done_ff;
endmodule

FILE: sv/tangent_bitangent_accumulate.sv
// Tangent/bitangent accumulator over a vertex store held in two RAMs.
// rsp_tvalid rises after accept once the item is done and any earlier result
// beat is taken. A triangle does corner reads, setup, 6 divisions on one shared
// 83-step serial divider and 3 read-modify-write passes; a degenerate one stops
// after setup. One item at a time; a waiting result beat does not block accept.
// Reset clears control state only; vertex contents are undefined until loaded.
// Depends on tba_pkg, tba_ram, tba_divider.
module tangent_bitangent_accumulate import tba_pkg::*; #(
   parameter int VERTEX_COUNT  = VertexCountDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // action, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
   // corner_a, corner_b, corner_c (low to high)
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tangent_x, _y, _z, bitangent_x, _y, _z, degenerate, saturated
   output logic [RspDataWidth-1:0] rsp_tdata
);
   localparam int AW = $clog2(VERTEX_COUNT);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_RDWAIT, S_RDOUT, S_CRD, S_DELTA, S_DET, S_NUM,
      S_DIV, S_URD, S_UWAIT, S_UWR, S_OUT
   } state_type;

   state_type state_ff;
   logic [ReqDataWidth-1:0]  req_ff;
   logic [1:0]               k_ff;
   logic [2:0]               j_ff;
   logic [VertexWordWidth-1:0] vtx_ff [3];
   logic signed [DeltaWidth-1:0] dp1_ff [3], dp2_ff [3];
   logic signed [DeltaWidth-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [ProductWidth-1:0] pa_ff, pb_ff;
   logic [DetWidth-1:0]      det_ff;
   logic [DataWidth-1:0]     q_ff [6];
   logic                     sat_ff, degen_ff, rsp_valid_ff, div_start_ff, issued_ff;
   logic [SumWordWidth-1:0]  res_ff;
   logic [RspDataWidth-1:0]  rsp_ff;

   logic                       v_we, s_we;
   logic [AW-1:0]              v_addr, s_addr;
   logic [VertexWordWidth-1:0] v_wdata, v_rdata;
   logic [SumWordWidth-1:0]    s_wdata, s_rdata, upd;
   logic [5:0]                 upd_clip;
   logic                       div_done, div_clip;
   logic [DataWidth-1:0]       div_quot;
   logic [DetWidth-1:0]        div_num;
   logic [AW-1:0]              corner [3];
   action_type                 act;

   assign act = action_type'(req_tdata[1:0]);
   assign corner[0] = AW'(32'(req_ff[185:174]) % VERTEX_COUNT);
   assign corner[1] = AW'(32'(req_ff[197:186]) % VERTEX_COUNT);
   assign corner[2] = AW'(32'(req_ff[209:198]) % VERTEX_COUNT);

   tba_ram #(.Width(VertexWordWidth), .Depth(VERTEX_COUNT)) u_vtx (
      .clock, .wr_en(v_we), .addr(v_addr), .wr_data(v_wdata), .rd_data(v_rdata));
   tba_ram #(.Width(SumWordWidth), .Depth(VERTEX_COUNT)) u_sum (
      .clock, .wr_en(s_we), .addr(s_addr), .wr_data(s_wdata), .rd_data(s_rdata));
   tba_divider #(.FracBits(FRACTION_BITS)) u_div (
      .clock, .reset, .start(div_start_ff), .num(div_num), .den(det_ff),
      .done(div_done), .quot(div_quot), .clip(div_clip));

   assign div_num = {pa_ff[ProductWidth-1], pa_ff} - {pb_ff[ProductWidth-1], pb_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         upd[i*32 +: 32] = sat_add32(s_rdata[i*32 +: 32], q_ff[i], upd_clip[i]);
         upd[(i+3)*32 +: 32] = sat_add32(s_rdata[(i+3)*32 +: 32], q_ff[i+3], upd_clip[i+3]);
      end
   end

   always_comb begin
      v_we = 1'b0; s_we = 1'b0;
      v_addr = AW'(32'(req_ff[13:2]) % VERTEX_COUNT);
      s_addr = v_addr;
      v_wdata = req_ff[2+IndexWidth+VertexWordWidth-1:2+IndexWidth];
      s_wdata = '0;
      case (state_ff)
         S_LOAD: begin
            v_we = 1'b1; s_we = 1'b1;
         end
         S_CRD: if (k_ff != 2'd3) v_addr = corner[k_ff];
         S_URD, S_UWAIT: s_addr = corner[k_ff];
         S_UWR: begin
            s_addr = corner[k_ff]; s_we = 1'b1; s_wdata = upd;
         end
         default: ;
      endcase
   end

   // Vertex word: x, y, z, u, v at 32-bit slots.
   function automatic logic signed [DeltaWidth-1:0] dlt(
      input logic [VertexWordWidth-1:0] a, input logic [VertexWordWidth-1:0] b,
      input int f);
      logic signed [DeltaWidth-1:0] r;
      r = DeltaWidth'($signed(b[f*32 +: 32])) - DeltaWidth'($signed(a[f*32 +: 32]));
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == S_DIV) && !div_start_ff && !div_done && issued_ff;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               req_ff <= req_tdata; sat_ff <= 1'b0; degen_ff <= 1'b0;
               k_ff <= '0; j_ff <= '0; issued_ff <= 1'b0;
               case (act)
                  ACT_LOAD:     state_ff <= S_LOAD;
                  ACT_TRIANGLE: state_ff <= S_CRD;
                  ACT_READ:     state_ff <= S_RDWAIT;
                  default: begin
                     res_ff <= '0; state_ff <= S_OUT;
                  end
               endcase
            end
            S_LOAD: begin
               res_ff <= '0; state_ff <= S_OUT;
            end
            S_RDWAIT: state_ff <= S_RDOUT;
            S_RDOUT: begin
               res_ff <= s_rdata; state_ff <= S_OUT;
            end
            S_CRD: begin
               if (k_ff != 2'd0) vtx_ff[k_ff - 1'b1] <= v_rdata;
               k_ff <= k_ff + 1'b1;
               if (k_ff == 2'd3) state_ff <= S_DELTA;
            end
            S_DELTA: begin
               for (int i = 0; i < 3; i++) begin
                  dp1_ff[i] <= dlt(vtx_ff[0], vtx_ff[1], i);
                  dp2_ff[i] <= dlt(vtx_ff[0], vtx_ff[2], i);
               end
               du1_ff <= dlt(vtx_ff[0], vtx_ff[1], 3);
               dv1_ff <= dlt(vtx_ff[0], vtx_ff[1], 4);
               du2_ff <= dlt(vtx_ff[0], vtx_ff[2], 3);
               dv2_ff <= dlt(vtx_ff[0], vtx_ff[2], 4);
               state_ff <= S_DET;
            end
            S_DET: begin
               pa_ff <= du1_ff * dv2_ff; pb_ff <= dv1_ff * du2_ff;
               j_ff <= '0;
               state_ff <= S_NUM;
            end
            S_NUM: begin
               if (!issued_ff) begin
                  det_ff <= div_num;
                  issued_ff <= 1'b1;
                  if (div_num == '0) begin
                     degen_ff <= 1'b1; res_ff <= '0; state_ff <= S_OUT;
                  end
               end else begin
                  if (j_ff < 3'd3) begin
                     pa_ff <= dp1_ff[j_ff[1:0]] * dv2_ff;
                     pb_ff <= dp2_ff[j_ff[1:0]] * dv1_ff;
                  end else begin
                     pa_ff <= dp2_ff[j_ff[1:0] - 2'd3] * du1_ff;
                     pb_ff <= dp1_ff[j_ff[1:0] - 2'd3] * du2_ff;
                  end
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!div_start_ff && !div_done && issued_ff) issued_ff <= 1'b0;
               if (div_done) begin
                  q_ff[j_ff] <= div_quot;
                  sat_ff <= sat_ff | div_clip;
                  issued_ff <= 1'b1;
                  if (j_ff == 3'd5) begin
                     k_ff <= '0; state_ff <= S_URD;
                  end else begin
                     j_ff <= j_ff + 1'b1; state_ff <= S_NUM;
                  end
               end
            end
            S_URD: state_ff <= S_UWAIT;
            S_UWAIT: state_ff <= S_UWR;
            S_UWR: begin
               sat_ff <= sat_ff | (upd_clip != '0);
               if (k_ff == 2'd2) begin
                  res_ff <= '0; state_ff <= S_OUT;
               end else begin
                  k_ff <= k_ff + 1'b1; state_ff <= S_URD;
               end
            end
            S_OUT: if (!rsp_valid_ff) begin
               rsp_ff <= RspDataWidth'({sat_ff, degen_ff, res_ff});
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   a_one_div: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> state_ff == S_DIV) else $error("divider started outside divide");
   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      v_we |-> !(state_ff == S_UWR)) else $error("vertex write during update");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
`endif
endmodule
